/* rtl/wps_pkg.sv */
// Shared constants for the waypoint path stepper and its checker.
package wps_pkg;

	localparam int COORD_W  = 12;
	localparam int MAX_WP   = 8;
	localparam int AIM_W    = 3;
	localparam int WPCNT_W  = 4;
	localparam int STEP_W   = 8;
	localparam int FUNC_W   = 2;
	localparam int DATA_W   = 64;
	localparam int ADDR_W   = 6;
	localparam int REG_W    = 3;

	localparam int DIF_W    = COORD_W + 1;
	localparam int PROD_W   = 2 * COORD_W;
	localparam int D2_W     = PROD_W + 1;
	localparam int ROOT_W   = (D2_W + 1) / 2;
	localparam int SH_W     = 2 * ROOT_W;
	localparam int SUB_W    = ROOT_W + 3;
	localparam int CNT_W    = $clog2(ROOT_W + 1);
	localparam int S2_W     = 2 * STEP_W;

	localparam logic [FUNC_W-1:0] FN_TICK  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_START = 2'd1;
	localparam logic [FUNC_W-1:0] FN_PLACE = 2'd2;

	localparam logic [REG_W-1:0] REG_WP_A  = 3'd0;
	localparam logic [REG_W-1:0] REG_COUNT = 3'd4;
	localparam logic [REG_W-1:0] REG_STEP  = 3'd5;

	localparam logic [COORD_W-1:0] POS_RST   = 12'd500;
	localparam logic [WPCNT_W-1:0] COUNT_RST = 4'd5;
	localparam logic [STEP_W-1:0]  STEP_RST  = 8'd5;

endpackage

/* rtl/waypoint_path_stepper.sv */
// Waypoint path stepper: tick sequencer with one shared multiplier and subtractor.
// Start, place, unused codes, other ticks: out_valid the cycle after acceptance.
// Tick while following, not done: step square, difference, squares, sum, compare,
//   then the 13-step square root and three 13-step divides on one subtractor.
// Each skipped waypoint reruns difference to compare; the last one is snapped to.
// One item at a time; reset restores position 500,500 and the register defaults.
module waypoint_path_stepper #(
	parameter int MAX_WAYPOINTS = wps_pkg::MAX_WP
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [wps_pkg::ADDR_W-1:0]   paddr,
	input  logic [wps_pkg::DATA_W-1:0]   pwdata,
	output logic [wps_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [wps_pkg::FUNC_W-1:0]   func,
	input  logic [wps_pkg::COORD_W-1:0]  place_x,
	input  logic [wps_pkg::COORD_W-1:0]  place_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [wps_pkg::COORD_W-1:0]  pos_x,
	output logic [wps_pkg::COORD_W-1:0]  pos_y,
	output logic [wps_pkg::AIM_W-1:0]    target_index,
	output logic                         following,
	output logic                         done_res
);
	import wps_pkg::*;

	localparam int WPI_W = $clog2(MAX_WAYPOINTS);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQS, ST_DIFF, ST_MULX, ST_MULY, ST_SUM, ST_CHK,
		ST_SQRT, ST_DIVK, ST_DIVX, ST_DIVY, ST_FIN
	} state_t;

	state_t state_q;

	logic [COORD_W-1:0] wp_x_q [MAX_WAYPOINTS];
	logic [COORD_W-1:0] wp_y_q [MAX_WAYPOINTS];
	logic [WPCNT_W-1:0] wp_count_q;
	logic [STEP_W-1:0]  step_q;

	logic [COORD_W-1:0] cur_x_q, cur_y_q, nx_q;
	logic [AIM_W-1:0]   aim_q;
	logic               follow_q, end_q, out_valid_q;

	logic signed [DIF_W-1:0] dx_q, dy_q;
	logic [S2_W-1:0]    s2_q;
	logic [PROD_W-1:0]  sqx_q, sqy_q;
	logic [D2_W-1:0]    d2_q;
	logic [SUB_W-1:0]   rem_q;
	logic [ROOT_W-1:0]  root_q, k_q;
	logic [SH_W-1:0]    sh_q;
	logic [CNT_W-1:0]   cnt_q;

	logic [REG_W-1:0]   reg_idx;
	logic               wr_en;
	logic [STEP_W-1:0]  step_eff;
	logic [WPCNT_W-1:0] n_eff, last_idx, aim_clamp;
	logic [WPI_W-1:0]   rd_idx;
	logic               aim_at_last;
	logic [COORD_W-1:0] aim_x, aim_y, mag_x, mag_y;
	logic signed [DIF_W-1:0] dx_c, dy_c, neg_x, neg_y;
	logic [COORD_W-1:0] mul_a, mul_b;
	logic [PROD_W-1:0]  mul_p;
	logic [SUB_W-1:0]   sub_a, sub_b, rem_nx;
	logic [SUB_W:0]     sub_d;
	logic               sub_ge;
	logic [ROOT_W-1:0]  quo_nx;
	logic               last_step;

	function automatic logic [COORD_W-1:0] floor_step(
		input logic [COORD_W-1:0] cur,
		input logic [ROOT_W-1:0]  quo,
		input logic [SUB_W-1:0]   rem,
		input logic               neg
	);
		logic [COORD_W-1:0] adj;
		adj = quo[COORD_W-1:0] + COORD_W'(neg && (rem != '0));
		return neg ? cur - adj : cur + adj;
	endfunction

	// configuration port
	assign reg_idx = paddr[ADDR_W-1:3];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < MAX_WAYPOINTS; w++) begin
				wp_x_q[w] <= '0;
				wp_y_q[w] <= '0;
			end
			wp_count_q <= COUNT_RST;
			step_q     <= STEP_RST;
		end else if (wr_en) begin
			for (int w = 0; w < MAX_WAYPOINTS; w++) begin
				if (reg_idx == REG_WP_A + REG_W'(w >> 1)) begin
					wp_x_q[w] <= pwdata[(w & 1) * 2 * COORD_W +: COORD_W];
					wp_y_q[w] <= pwdata[(w & 1) * 2 * COORD_W + COORD_W +: COORD_W];
				end
			end
			if (reg_idx == REG_COUNT) wp_count_q <= pwdata[WPCNT_W-1:0];
			if (reg_idx == REG_STEP)  step_q     <= pwdata[STEP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		for (int w = 0; w < MAX_WAYPOINTS; w++) begin
			if (reg_idx == REG_WP_A + REG_W'(w >> 1)) begin
				prdata[(w & 1) * 2 * COORD_W +: COORD_W]           = wp_x_q[w];
				prdata[(w & 1) * 2 * COORD_W + COORD_W +: COORD_W] = wp_y_q[w];
			end
		end
		if (reg_idx == REG_COUNT) prdata = DATA_W'(wp_count_q);
		if (reg_idx == REG_STEP)  prdata = DATA_W'(step_q);
	end

	// derived operands
	assign step_eff = (step_q == '0) ? STEP_W'(1) : step_q;

	always_comb begin
		if (wp_count_q == '0)
			n_eff = WPCNT_W'(1);
		else if (wp_count_q > WPCNT_W'(MAX_WAYPOINTS))
			n_eff = WPCNT_W'(MAX_WAYPOINTS);
		else
			n_eff = wp_count_q;
	end

	assign last_idx    = n_eff - WPCNT_W'(1);
	assign aim_at_last = WPCNT_W'(aim_q) >= last_idx;
	assign aim_clamp   = (WPCNT_W'(aim_q) >= WPCNT_W'(MAX_WAYPOINTS)) ?
		WPCNT_W'(MAX_WAYPOINTS - 1) : WPCNT_W'(aim_q);
	assign rd_idx = aim_clamp[WPI_W-1:0];
	assign aim_x  = wp_x_q[rd_idx];
	assign aim_y  = wp_y_q[rd_idx];

	assign dx_c  = $signed({1'b0, aim_x}) - $signed({1'b0, cur_x_q});
	assign dy_c  = $signed({1'b0, aim_y}) - $signed({1'b0, cur_y_q});
	assign neg_x = -dx_q;
	assign neg_y = -dy_q;
	assign mag_x = dx_q[DIF_W-1] ? neg_x[COORD_W-1:0] : dx_q[COORD_W-1:0];
	assign mag_y = dy_q[DIF_W-1] ? neg_y[COORD_W-1:0] : dy_q[COORD_W-1:0];

	// shared multiplier
	always_comb begin
		case (state_q)
			ST_SQS:  mul_a = COORD_W'(step_eff);
			ST_MULX: mul_a = mag_x;
			default: mul_a = mag_y;
		endcase
		mul_b = mul_a;
	end
	assign mul_p = mul_a * mul_b;

	// shared compare and subtract: one root digit or one quotient bit per cycle
	always_comb begin
		case (state_q)
			ST_SQRT: begin
				sub_a = {rem_q[SUB_W-3:0], sh_q[SH_W-1 -: 2]};
				sub_b = SUB_W'({root_q, 2'b01});
			end
			ST_DIVK: begin
				sub_a = {rem_q[SUB_W-2:0], sh_q[SH_W-1]};
				sub_b = SUB_W'(step_eff);
			end
			default: begin
				sub_a = {rem_q[SUB_W-2:0], sh_q[SH_W-1]};
				sub_b = SUB_W'(k_q);
			end
		endcase
	end
	assign sub_d     = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_ge    = !sub_d[SUB_W];
	assign rem_nx    = sub_ge ? sub_d[SUB_W-1:0] : sub_a;
	assign quo_nx    = {root_q[ROOT_W-2:0], sub_ge};
	assign last_step = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_x_q     <= POS_RST;
			cur_y_q     <= POS_RST;
			aim_q       <= '0;
			follow_q    <= 1'b0;
			end_q       <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						case (func)
							FN_TICK: begin
								if (follow_q && !end_q) begin
									state_q     <= ST_SQS;
									out_valid_q <= 1'b0;
								end else out_valid_q <= 1'b1;
							end
							FN_START: begin
								follow_q    <= 1'b1;
								end_q       <= 1'b0;
								aim_q       <= '0;
								cur_x_q     <= wp_x_q[0];
								cur_y_q     <= wp_y_q[0];
								out_valid_q <= 1'b1;
							end
							FN_PLACE: begin
								cur_x_q     <= place_x;
								cur_y_q     <= place_y;
								follow_q    <= 1'b0;
								out_valid_q <= 1'b1;
							end
							default: out_valid_q <= 1'b1;
						endcase
					end else if (out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_SQS: begin
					s2_q    <= mul_p[S2_W-1:0];
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					dx_q    <= dx_c;
					dy_q    <= dy_c;
					state_q <= ST_MULX;
				end
				ST_MULX: begin
					sqx_q   <= mul_p;
					state_q <= ST_MULY;
				end
				ST_MULY: begin
					sqy_q   <= mul_p;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					d2_q    <= D2_W'(sqx_q) + D2_W'(sqy_q);
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (d2_q >= D2_W'(s2_q)) begin
						sh_q    <= SH_W'(d2_q);
						rem_q   <= '0;
						root_q  <= '0;
						cnt_q   <= CNT_W'(ROOT_W - 1);
						state_q <= ST_SQRT;
					end else if (aim_at_last) begin
						cur_x_q <= aim_x;
						cur_y_q <= aim_y;
						end_q   <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						aim_q   <= aim_q + AIM_W'(1);
						state_q <= ST_DIFF;
					end
				end
				ST_SQRT: begin
					if (last_step) begin
						sh_q    <= {quo_nx, ROOT_W'(0)};
						rem_q   <= '0;
						root_q  <= '0;
						cnt_q   <= CNT_W'(ROOT_W - 1);
						state_q <= ST_DIVK;
					end else begin
						rem_q  <= rem_nx;
						root_q <= quo_nx;
						sh_q   <= sh_q << 2;
						cnt_q  <= cnt_q - CNT_W'(1);
					end
				end
				ST_DIVK: begin
					if (last_step) begin
						k_q     <= (quo_nx == '0) ? ROOT_W'(1) : quo_nx;
						sh_q    <= {ROOT_W'(mag_x), ROOT_W'(0)};
						rem_q   <= '0;
						root_q  <= '0;
						cnt_q   <= CNT_W'(ROOT_W - 1);
						state_q <= ST_DIVX;
					end else begin
						rem_q  <= rem_nx;
						root_q <= quo_nx;
						sh_q   <= sh_q << 1;
						cnt_q  <= cnt_q - CNT_W'(1);
					end
				end
				ST_DIVX: begin
					if (last_step) begin
						nx_q    <= floor_step(cur_x_q, quo_nx, rem_nx, dx_q[DIF_W-1]);
						sh_q    <= {ROOT_W'(mag_y), ROOT_W'(0)};
						rem_q   <= '0;
						root_q  <= '0;
						cnt_q   <= CNT_W'(ROOT_W - 1);
						state_q <= ST_DIVY;
					end else begin
						rem_q  <= rem_nx;
						root_q <= quo_nx;
						sh_q   <= sh_q << 1;
						cnt_q  <= cnt_q - CNT_W'(1);
					end
				end
				ST_DIVY: begin
					if (last_step) begin
						cur_x_q <= nx_q;
						cur_y_q <= floor_step(cur_y_q, quo_nx, rem_nx, dy_q[DIF_W-1]);
						state_q <= ST_FIN;
					end else begin
						rem_q  <= rem_nx;
						root_q <= quo_nx;
						sh_q   <= sh_q << 1;
						cnt_q  <= cnt_q - CNT_W'(1);
					end
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready     = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign out_valid    = out_valid_q;
	assign pos_x        = cur_x_q;
	assign pos_y        = cur_y_q;
	assign target_index = aim_q;
	assign following    = follow_q;
	assign done_res     = end_q;

endmodule

/* rtl/wps_checker.sv */
// Port-level checks for the waypoint path stepper, bound to the top level.
module wps_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic [wps_pkg::FUNC_W-1:0]   func,
	input logic [wps_pkg::COORD_W-1:0]  place_x,
	input logic [wps_pkg::COORD_W-1:0]  place_y,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [wps_pkg::COORD_W-1:0]  pos_x,
	input logic [wps_pkg::COORD_W-1:0]  pos_y,
	input logic [wps_pkg::AIM_W-1:0]    target_index,
	input logic                         following,
	input logic                         done_res
);
	import wps_pkg::*;

	// held result transaction keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y)
			&& $stable(target_index) && $stable(following) && $stable(done_res))
		else $error("result changed while stalled");

	// no new transaction while an untaken result is held
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid && !out_ready))
		else $error("input ready while output blocked");

	a_place: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func == FN_PLACE |=> out_valid
			&& pos_x == $past(place_x) && pos_y == $past(place_y) && !following)
		else $error("place result wrong");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func == FN_START |=> out_valid
			&& following && !done_res && target_index == '0)
		else $error("start result wrong");

endmodule

bind waypoint_path_stepper wps_checker u_wps_checker (.*);

/* bench/tb_top.sv */
// Testbench for waypoint_path_stepper: predicts each result and checks it under random stalls.
module tb_top;
	import wps_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [AIM_W-1:0]   aim;
		logic               follow;
		logic               done;
	} pose_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid;
	logic                in_ready;
	logic [FUNC_W-1:0]   func;
	logic [COORD_W-1:0]  place_x;
	logic [COORD_W-1:0]  place_y;
	logic                out_valid;
	logic                out_ready;
	logic [COORD_W-1:0]  pos_x;
	logic [COORD_W-1:0]  pos_y;
	logic [AIM_W-1:0]    target_index;
	logic                following;
	logic                done_res;

	waypoint_path_stepper u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.place_x      (place_x),
		.place_y      (place_y),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.target_index (target_index),
		.following    (following),
		.done_res     (done_res)
	);

	// predicted block state and register copies
	logic [47:0]        wp_regs [4];
	logic [WPCNT_W-1:0] wp_count;
	logic [STEP_W-1:0]  step_len;
	logic [COORD_W-1:0] trk_x;
	logic [COORD_W-1:0] trk_y;
	logic [AIM_W-1:0]   trk_aim;
	logic               trk_follow;
	logic               trk_done;

	pose_t pending_poses [$];
	pose_t want;
	int    errors;
	int    cycles;
	int    items_sent;
	int    results_seen;
	int    paths_finished;
	int    reg_writes;
	int    tx_idle_pct;
	int    rx_idle_pct;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				pending_poses.size());
			$display("tb_top NOT OK");
			$finish;
		end
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

	function automatic int wp_coord(int idx, bit is_y);
		logic [47:0] r;
		r = wp_regs[2'(idx >> 1)];
		return int'((r >> ((((idx & 1) * 2) + is_y) * COORD_W)) & 48'hFFF);
	endfunction

	function automatic logic [47:0] pack_pair(int x0, int y0, int x1, int y1);
		return {COORD_W'(y1), COORD_W'(x1), COORD_W'(y0), COORD_W'(x0)};
	endfunction

	function automatic int int_sqrt(longint v);
		int     r;
		longint c;
		r = 0;
		for (int b = ROOT_W; b >= 0; b--) begin
			c = r | (1 << b);
			if (c * c <= v)
				r = int'(c);
		end
		return r;
	endfunction

	function automatic int floor_div(int a, int b);
		int q;
		q = a / b;
		if ((a % b != 0) && (a < 0))
			q--;
		return q;
	endfunction

	function automatic void walk_one_tick();
		int     n;
		int     s;
		int     i;
		int     dx;
		int     dy;
		int     k;
		int     nx;
		int     ny;
		longint d2;
		longint s2;
		n = int'(wp_count);
		if (n == 0)
			n = 1;
		if (n > MAX_WP)
			n = MAX_WP;
		s = (step_len == 0) ? 1 : int'(step_len);
		s2 = longint'(s) * s;
		while (1) begin
			i = (int'(trk_aim) >= MAX_WP) ? MAX_WP - 1 : int'(trk_aim);
			dx = wp_coord(i, 1'b0) - int'(trk_x);
			dy = wp_coord(i, 1'b1) - int'(trk_y);
			d2 = longint'(dx) * dx + longint'(dy) * dy;
			if (d2 >= s2)
				break;
			if (int'(trk_aim) >= n - 1) begin
				trk_x = COORD_W'(wp_coord(i, 1'b0));
				trk_y = COORD_W'(wp_coord(i, 1'b1));
				trk_done = 1'b1;
				paths_finished++;
				return;
			end
			trk_aim = trk_aim + 1'b1;
		end
		k = int_sqrt(d2) / s;
		if (k < 1)
			k = 1;
		nx = int'(trk_x) + floor_div(dx, k);
		ny = int'(trk_y) + floor_div(dy, k);
		trk_x = nx[COORD_W-1:0];
		trk_y = ny[COORD_W-1:0];
	endfunction

	function automatic pose_t predict_pose(logic [FUNC_W-1:0] f, logic [COORD_W-1:0] px,
			logic [COORD_W-1:0] py);
		pose_t p;
		case (f)
			FN_TICK: begin
				if (trk_follow && !trk_done)
					walk_one_tick();
			end
			FN_START: begin
				trk_follow = 1'b1;
				trk_done = 1'b0;
				trk_aim = '0;
				trk_x = COORD_W'(wp_coord(0, 1'b0));
				trk_y = COORD_W'(wp_coord(0, 1'b1));
			end
			FN_PLACE: begin
				trk_x = px;
				trk_y = py;
				trk_follow = 1'b0;
			end
			default: ;
		endcase
		p.x = trk_x;
		p.y = trk_y;
		p.aim = trk_aim;
		p.follow = trk_follow;
		p.done = trk_done;
		return p;
	endfunction

	function automatic void check_field(string name, int exp_v, logic [COORD_W-1:0] act_v);
		if (act_v !== COORD_W'(exp_v)) begin
			$error("%s expected %0d actual %0d", name, exp_v, act_v);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			results_seen++;
			if (pending_poses.size() == 0) begin
				$error("result with no transaction pending");
				errors++;
			end else begin
				want = pending_poses.pop_front();
				check_field("pos_x", want.x, pos_x);
				check_field("pos_y", want.y, pos_y);
				check_field("target_index", want.aim, COORD_W'(target_index));
				check_field("following", want.follow, COORD_W'(following));
				check_field("done_res", want.done, COORD_W'(done_res));
			end
		end
	end

	// entered and left at a falling edge
	task automatic send_item(logic [FUNC_W-1:0] f, logic [COORD_W-1:0] px,
			logic [COORD_W-1:0] py);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		place_x <= px;
		place_y <= py;
		do
			@(posedge clk);
		while (!in_ready);
		pending_poses.push_back(predict_pose(f, px, py));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_tick();
		send_item(FN_TICK, COORD_W'($urandom), COORD_W'($urandom));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_poses.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [REG_W-1:0] idx, logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (idx < REG_COUNT)
			wp_regs[idx[1:0]] = value[47:0];
		else if (idx == REG_COUNT)
			wp_count = value[WPCNT_W-1:0];
		else if (idx == REG_STEP)
			step_len = value[STEP_W-1:0];
		reg_writes++;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic test_idle_codes();
		send_item(FN_UNUSED, '1, '1);
		send_tick();
	endtask

	task automatic test_place_extremes();
		send_item(FN_PLACE, '0, '0);
		send_item(FN_PLACE, '1, '1);
		send_item(FN_PLACE, 12'hAAA, 12'h555);
	endtask

	task automatic test_full_path();
		int guard;
		drain_results();
		write_reg(REG_WP_A, pack_pair(100, 100, 700, 100));
		write_reg(REG_WP_A + REG_W'(1), pack_pair(700, 900, 4000, 4000));
		write_reg(REG_COUNT, 3);
		write_reg(REG_STEP, 255);
		send_item(FN_START, '0, '0);
		guard = 0;
		while (!trk_done && guard < 12) begin
			send_tick();
			guard++;
		end
		send_tick();
		// restart clears done, place keeps aim and done
		send_item(FN_START, '0, '0);
		send_tick();
		send_item(FN_PLACE, COORD_W'(2000), COORD_W'(3000));
		send_tick();
	endtask

	task automatic test_range_clamps();
		drain_results();
		write_reg(REG_COUNT, 0);
		write_reg(REG_STEP, 0);
		send_item(FN_START, '0, '0);
		send_tick();
		send_tick();
		drain_results();
		write_reg(REG_WP_A, pack_pair(100, 100, 300, 100));
		write_reg(REG_WP_A + REG_W'(1), pack_pair(500, 100, 700, 100));
		write_reg(REG_WP_A + REG_W'(2), pack_pair(3000, 3000, 3100, 3000));
		write_reg(REG_WP_A + REG_W'(3), pack_pair(3200, 3000, 4095, 0));
		write_reg(REG_COUNT, 15);
		write_reg(REG_STEP, 255);
		send_item(FN_START, '0, '0);
		send_tick();
		send_tick();
		send_tick();
		// aim now sits past the shortened list
		drain_results();
		write_reg(REG_COUNT, 2);
		send_tick();
		send_tick();
		send_tick();
	endtask

	function automatic int near_coord(int base);
		int v;
		v = base + int'($urandom_range(0, 600)) - 300;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return v;
	endfunction

	task automatic load_random_path();
		bit          cluster;
		int          base_x;
		int          base_y;
		logic [63:0] raw;
		cluster = ($urandom_range(0, 3) != 0);
		base_x = $urandom_range(0, 4095);
		base_y = $urandom_range(0, 4095);
		for (int r = 0; r < 4; r++) begin
			raw = {$urandom, $urandom};
			if (cluster)
				raw = pack_pair(near_coord(base_x), near_coord(base_y),
					near_coord(base_x), near_coord(base_y));
			write_reg(REG_WP_A + REG_W'(r), {16'h0, raw[47:0]});
		end
		if ($urandom_range(0, 9) == 0)
			write_reg(REG_COUNT, $urandom_range(0, 15));
		else
			write_reg(REG_COUNT, $urandom_range(2, MAX_WP));
		if ($urandom_range(0, 9) == 0)
			write_reg(REG_STEP, $urandom_range(0, 255));
		else if (cluster)
			write_reg(REG_STEP, $urandom_range(20, 255));
		else
			write_reg(REG_STEP, $urandom_range(128, 255));
	endtask

	task automatic test_random_paths(int n_items, int tx_pct, int rx_pct);
		int          sent;
		int          ticks;
		int          pick;
		logic [FUNC_W-1:0] f;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		sent = 0;
		while (sent < n_items) begin
			// register updates only once every result is back
			drain_results();
			load_random_path();
			send_item(FN_START, COORD_W'($urandom), COORD_W'($urandom));
			sent++;
			ticks = $urandom_range(4, 40);
			for (int i = 0; i < ticks && sent < n_items; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 85)
					f = FN_TICK;
				else if (pick < 90)
					f = FN_PLACE;
				else if (pick < 95)
					f = FN_UNUSED;
				else
					f = FN_START;
				send_item(f, COORD_W'($urandom), COORD_W'($urandom));
				sent++;
				if (trk_done && $urandom_range(0, 3) != 0)
					break;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		func = FN_TICK;
		place_x = '0;
		place_y = '0;
		for (int r = 0; r < 4; r++)
			wp_regs[r] = '0;
		wp_count = COUNT_RST;
		step_len = STEP_RST;
		trk_x = POS_RST;
		trk_y = POS_RST;
		trk_aim = '0;
		trk_follow = 1'b0;
		trk_done = 1'b0;
		items_sent = 0;
		paths_finished = 0;
		reg_writes = 0;
		tx_idle_pct = 8;
		rx_idle_pct = 51;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_idle_codes();
		test_place_extremes();
		test_full_path();
		test_range_clamps();
		test_random_paths(150, 8, 51);
		test_random_paths(150, 51, 8);
		test_random_paths(150, 0, 0);

		drain_results();
		repeat (100) @(posedge clk);
		$display("covered %0d transactions and %0d results over %0d register writes,",
			items_sent, results_seen, reg_writes);
		$display("with %0d paths followed to the last waypoint", paths_finished);
		if (errors == 0 && pending_poses.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

/* waypoint_path_stepper.f */
rtl/wps_pkg.sv
rtl/waypoint_path_stepper.sv
rtl/wps_checker.sv
bench/tb_top.sv
